FILE: rtl/krt_pkg.sv
// krt_pkg: shared types and codes for the keyed record table
// used by krt_cell and keyed_record_table; no dependencies
`timescale 1ns / 1ps

package krt_pkg;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_FULL     = 3'd2,
    ST_DELETED  = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_BADKEY   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_LAUNCH,
    FSM_SCAN,
    FSM_FINISH
  } fsm_t;

  // input transaction payload
  typedef struct packed {
    logic        mode;
    logic [15:0] roll_number;
    logic [63:0] subj_key;
    logic [9:0]  marks;
  } req_t;

  // result transaction payload
  typedef struct packed {
    status_t     status;
    logic [8:0]  entry_count;
    logic        table_empty;
    logic        table_full;
  } rsp_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic active;
    logic matched;
    logic claimed;
  } tok_t;

  // end-of-scan commit broadcast to all cells
  typedef struct packed {
    logic en;
    logic wr;
  } cmt_t;

endpackage

FILE: rtl/krt_cell.sv
// krt_cell: one table slot plus one stage of the search token chain
// depends on krt_pkg
`timescale 1ns / 1ps

module krt_cell
  import krt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  req_t key,
  input  tok_t tok_in,
  input  cmt_t cmt,
  output tok_t tok_out
);

  logic [15:0] roll_r, roll_nxt;
  logic [63:0] subj_r, subj_nxt;
  logic [9:0]  marks_r, marks_nxt;
  logic        pend_r, pend_nxt;
  tok_t        tok_r, tok_nxt;
  logic        hit;
  logic        claim;
  logic        is_ins;

  always_comb begin
    is_ins    = (key.mode == MODE_INSERT);
    hit       = tok_in.active && (roll_r != '0) && (roll_r == key.roll_number)
                && (subj_r == key.subj_key);
    claim     = tok_in.active && is_ins && (roll_r == '0) && !tok_in.claimed;
    roll_nxt  = roll_r;
    subj_nxt  = subj_r;
    marks_nxt = marks_r;
    pend_nxt  = pend_r;
    if (hit) begin
      if (is_ins) begin
        marks_nxt = key.marks;
      end else begin
        roll_nxt = '0;
      end
    end
    if (claim) begin
      pend_nxt = 1'b1;
    end
    // a tentative claim is either filled or dropped once the scan ends
    if (cmt.en && pend_r) begin
      pend_nxt = 1'b0;
      if (cmt.wr) begin
        roll_nxt  = key.roll_number;
        subj_nxt  = key.subj_key;
        marks_nxt = key.marks;
      end
    end
    tok_nxt.active  = tok_in.active;
    tok_nxt.matched = tok_in.matched | hit;
    tok_nxt.claimed = tok_in.claimed | claim;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_r <= '0;
      pend_r <= 1'b0;
      tok_r  <= '0;
    end else begin
      roll_r <= roll_nxt;
      pend_r <= pend_nxt;
      tok_r  <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    subj_r  <= subj_nxt;
    marks_r <= marks_nxt;
  end

  assign tok_out = tok_r;

endmodule

FILE: rtl/keyed_record_table.sv
// keyed_record_table: top level, request control, occupancy count and cell chain
// depends on krt_pkg and krt_cell
`timescale 1ns / 1ps

//  channel   ports                           payload
//  input     in_valid / in_ready / in_data   req_t: mode, roll_number, subj_key, marks
//  result    out_valid / out_ready / out_data rsp_t: status, entry_count, empty, full
//
//  a transaction with a nonzero roll number shows its result after a launch state, the
//  search token's walk along the cell chain one slot per cycle, and a finish state that
//  commits and publishes once the output register can take the result
//  a zero roll number skips the scan and goes straight to the finish state with a bad-key status
//  reset clears every slot to empty and the count to zero at once, no clearing pass
//  a result waiting in the output register does not block the next input transaction;
//  only its commit waits for the output register to free up

module keyed_record_table
  import krt_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = (CW > 9) ? CW : 9;

  fsm_t          state_r, state_nxt;
  req_t          req_r, req_nxt;
  status_t       status_r, status_nxt;
  logic          wr_r, wr_nxt;       // commit fills the claimed slot
  logic          inc_r, inc_nxt;
  logic          dec_r, dec_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  rsp_t          out_data_r, out_data_nxt;
  logic [EW-1:0] cnt_ext;
  logic          launch;
  cmt_t          cmt;
  tok_t          tok_link [TABLE_DEPTH+1];

  // token enters the first cell in the cycle after the key is latched, during the launch state
  assign tok_link[0] = '{active: launch, matched: 1'b0, claimed: 1'b0};

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    krt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .key     (req_r),
      .tok_in  (tok_link[i]),
      .cmt     (cmt),
      .tok_out (tok_link[i+1])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    status_nxt    = status_r;
    wr_nxt        = wr_r;
    inc_nxt       = inc_r;
    dec_nxt       = dec_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    in_ready      = 1'b0;
    launch        = 1'b0;
    cmt           = '0;
    cnt_ext       = '0;
    case (state_r)
      FSM_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt = in_data;
          wr_nxt  = 1'b0;
          inc_nxt = 1'b0;
          dec_nxt = 1'b0;
          if (in_data.roll_number == '0) begin
            status_nxt = ST_BADKEY;
            state_nxt  = FSM_FINISH;
          end else begin
            state_nxt = FSM_LAUNCH;
          end
        end
      end
      FSM_LAUNCH: begin
        launch    = 1'b1;
        state_nxt = FSM_SCAN;
      end
      FSM_SCAN: begin
        // token reached the far end: every slot has been checked
        if (tok_link[TABLE_DEPTH].active) begin
          state_nxt = FSM_FINISH;
          if (req_r.mode == MODE_INSERT) begin
            if (tok_link[TABLE_DEPTH].matched) begin
              status_nxt = ST_UPDATED;
            end else if (tok_link[TABLE_DEPTH].claimed) begin
              status_nxt = ST_INSERTED;
              wr_nxt     = 1'b1;
              inc_nxt    = 1'b1;
            end else begin
              status_nxt = ST_FULL;
            end
          end else begin
            if (tok_link[TABLE_DEPTH].matched) begin
              status_nxt = ST_DELETED;
              dec_nxt    = 1'b1;
            end else begin
              status_nxt = ST_NOTFOUND;
            end
          end
        end
      end
      FSM_FINISH: begin
        // commit and publish only once the output register can take the result
        if (!out_valid_r || out_ready) begin
          cmt.en        = 1'b1;
          cmt.wr        = wr_r;
          cnt_nxt       = cnt_r + CW'(inc_r) - CW'(dec_r);
          cnt_ext       = EW'(cnt_nxt);
          out_valid_nxt = 1'b1;
          out_data_nxt.status      = status_r;
          out_data_nxt.entry_count = cnt_ext[8:0];
          out_data_nxt.table_empty = (cnt_nxt == '0);
          out_data_nxt.table_full  = (cnt_nxt == CW'(TABLE_DEPTH));
          state_nxt     = FSM_IDLE;
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      wr_r        <= 1'b0;
      inc_r       <= 1'b0;
      dec_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      wr_r        <= wr_nxt;
      inc_r       <= inc_nxt;
      dec_r       <= dec_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // occupancy never exceeds the table size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TABLE_DEPTH))
    else $error("occupancy count above table depth");

  // no search token may still be at the far end of the chain while idle
  a_chain_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_IDLE) |-> !tok_link[TABLE_DEPTH].active)
    else $error("search token left over in idle");

  // a slot is only filled by an insert that found neither match nor full table
  a_fill_status: assert property (@(posedge clk) disable iff (!rst_n)
    (cmt.en && cmt.wr) |-> (status_r == ST_INSERTED) && (req_r.mode == MODE_INSERT))
    else $error("slot fill without insert status");

  // a valid key always starts a scan
  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.roll_number != '0)) |=> (state_r == FSM_LAUNCH))
    else $error("scan not launched");

endmodule
